// ===== hdl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

    // Width of every byte that moves through the core.
    localparam int BYTE_W = 8;

    // Depth of the permutation memory; fixed by the cipher.
    localparam int PERM_DEPTH = 256;

    // Index of the last permutation entry; the key schedule ends on it.
    localparam logic [BYTE_W-1:0] PERM_LAST = 8'hFF;

    // Default capacity of the key store.
    localparam int KEY_BYTES_MAX_DEF = 256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic key_wr;      // store the input key byte
        logic data_start;  // step index i, latch data byte, read S[i]
        logic sch_clear;   // permutation to identity, indices to zero
        logic sch_rd_x;    // read S[n] and the current key byte
        logic rd_y;        // form index j, read S[j]
        logic wr_x;        // write first swap entry, read output entry (data only)
        logic wr_y;        // write second swap entry
        logic out_load;    // load the output byte register
        logic sch_next;    // advance schedule counter and key index
        logic sched;       // current sequence belongs to the key schedule
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sch_done;    // the schedule step just run is the last one
    } t_dp_sts;

endpackage : rc4_pkg

// ===== hdl/rc4_dp.sv =====
// ----------------------------------------------------------------------------
// rc4_dp
// Datapath of the RC4 core: permutation memory, key store, indices and the
// output byte register.
// ----------------------------------------------------------------------------
module rc4_dp #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rc4_pkg::t_dp_cmd            i_cmd,
    output rc4_pkg::t_dp_sts            o_sts,
    input  logic [rc4_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic                        i_last,
    output logic [rc4_pkg::BYTE_W-1:0]  o_out_byte
);
    import rc4_pkg::*;

    localparam int KW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int CW = $clog2(KEY_BYTES_MAX + 1);
    localparam logic [CW-1:0] KMAX = CW'(KEY_BYTES_MAX);

    // Permutation memory with one valid bit per entry; an entry that is
    // not valid holds its own index.
    logic [BYTE_W-1:0] r_perm [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_perm_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld;
    logic [BYTE_W-1:0] r_rd_addr;

    logic [BYTE_W-1:0] r_key_mem [KEY_BYTES_MAX];
    logic [BYTE_W-1:0] r_key_q;
    logic [CW-1:0]     r_key_count;
    logic              r_loading;
    logic [KW-1:0]     r_k;

    logic [BYTE_W-1:0] r_i, r_j, r_n, r_x, r_y, r_a, r_b, r_byte;
    logic [BYTE_W-1:0] r_out_byte;

    logic [BYTE_W-1:0] rd_eff, y_val, t_val;
    logic [BYTE_W-1:0] rd_addr, wr_addr, wr_data;
    logic              rd_en, wr_en;
    logic [CW-1:0]     key_base, k_inc;
    logic [KW-1:0]     k_next;

    assign rd_eff = r_rd_vld ? r_rd_data : r_rd_addr;
    assign y_val  = r_j + rd_eff + (i_cmd.sched ? r_key_q : '0);

    // Output entry after the swap: the later write wins when both match.
    always_comb begin
        if (r_rd_addr == r_y) begin
            t_val = r_a;
        end else if (r_rd_addr == r_x) begin
            t_val = r_b;
        end else begin
            t_val = rd_eff;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_n;
        if (i_cmd.data_start) begin
            rd_en   = 1'b1;
            rd_addr = r_i + 8'd1;
        end else if (i_cmd.sch_rd_x) begin
            rd_en   = 1'b1;
            rd_addr = r_n;
        end else if (i_cmd.rd_y) begin
            rd_en   = 1'b1;
            rd_addr = y_val;
        end else if (i_cmd.wr_x && !i_cmd.sched) begin
            rd_en   = 1'b1;
            rd_addr = r_a + rd_eff;
        end
    end

    assign wr_en   = i_cmd.wr_x | i_cmd.wr_y;
    assign wr_addr = i_cmd.wr_x ? r_x : r_y;
    assign wr_data = i_cmd.wr_x ? rd_eff : r_a;

    assign key_base = r_loading ? r_key_count : '0;
    assign k_inc    = CW'(r_k) + CW'(1);
    assign k_next   = (k_inc >= r_key_count) ? '0 : r_k + KW'(1);

    // Memory arrays.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_perm[rd_addr];
            r_rd_vld  <= r_perm_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (wr_en) begin
            r_perm[wr_addr] <= wr_data;
        end
        if (i_cmd.key_wr && (key_base < KMAX)) begin
            r_key_mem[key_base[KW-1:0]] <= i_byte_in;
        end
        if (i_cmd.sch_rd_x) begin
            r_key_q <= r_key_mem[r_k];
        end
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_vld  <= '0;
            r_key_count <= '0;
            r_loading   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_k         <= '0;
        end else begin
            if (i_cmd.sch_clear) begin
                r_perm_vld <= '0;
            end else if (wr_en) begin
                r_perm_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.key_wr) begin
                r_key_count <= (key_base < KMAX) ? key_base + CW'(1) : key_base;
                r_loading   <= !i_last;
            end
            if (i_cmd.data_start) begin
                r_loading <= 1'b0;
                r_i       <= r_i + 8'd1;
            end
            if (i_cmd.sch_clear) begin
                r_i <= '0;
                r_j <= '0;
                r_n <= '0;
                r_k <= '0;
            end
            if (i_cmd.rd_y) begin
                r_j <= y_val;
            end
            if (i_cmd.sch_next) begin
                r_n <= r_n + 8'd1;
                r_k <= k_next;
                // The keystream starts with index j back at zero.
                if (r_n == PERM_LAST) begin
                    r_j <= '0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.data_start) begin
            r_x    <= r_i + 8'd1;
            r_byte <= i_byte_in;
        end
        if (i_cmd.sch_rd_x) begin
            r_x <= r_n;
        end
        if (i_cmd.rd_y) begin
            r_y <= y_val;
            r_a <= rd_eff;
        end
        if (i_cmd.wr_x) begin
            r_b <= rd_eff;
        end
        if (i_cmd.out_load) begin
            r_out_byte <= r_byte ^ t_val;
        end
    end

    assign o_sts.sch_done = (r_n == PERM_LAST);
    assign o_out_byte     = r_out_byte;

endmodule : rc4_dp

// ===== hdl/rc4_ctrl.sv =====
// ----------------------------------------------------------------------------
// rc4_ctrl
// Controller of the RC4 core: sequences key loads, the key schedule and
// data bytes, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module rc4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rc4_pkg::t_dp_cmd  o_cmd,
    input  rc4_pkg::t_dp_sts  i_sts
);
    import rc4_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCH_CLR,
        S_SCH_RD,
        S_RD_Y,
        S_WR_X,
        S_WR_Y
    } t_state;

    t_state  r_state, n_state;
    logic    r_sched, n_sched;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        cmd.sched   = r_sched;
        n_state     = r_state;
        n_sched     = r_sched;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op) begin
                        cmd.data_start = 1'b1;
                        n_sched        = 1'b0;
                        n_state        = S_RD_Y;
                    end else begin
                        cmd.key_wr = 1'b1;
                        if (i_last) begin
                            n_state = S_SCH_CLR;
                        end
                    end
                end
            end
            S_SCH_CLR: begin
                cmd.sch_clear = 1'b1;
                n_sched       = 1'b1;
                n_state       = S_SCH_RD;
            end
            S_SCH_RD: begin
                cmd.sch_rd_x = 1'b1;
                n_state      = S_RD_Y;
            end
            S_RD_Y: begin
                cmd.rd_y = 1'b1;
                n_state  = S_WR_X;
            end
            S_WR_X: begin
                cmd.wr_x = 1'b1;
                n_state  = S_WR_Y;
            end
            S_WR_Y: begin
                if (r_sched) begin
                    cmd.wr_y     = 1'b1;
                    cmd.sch_next = 1'b1;
                    n_state      = i_sts.sch_done ? S_IDLE : S_SCH_RD;
                end else if (!(r_out_valid && i_out_stall)) begin
                    cmd.wr_y     = 1'b1;
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sched     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sched     <= n_sched;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A new result only comes out of the last step of a data byte.
    a_out_from_wr_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WR_Y && !r_sched))
        else $error("output valid rose outside the data write-back step");

    // A data byte waits in write-back while the previous result is unread.
    a_hold_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR_Y && !r_sched && r_out_valid && i_out_stall)
        |=> (r_state == S_WR_Y && $stable(r_out_valid)))
        else $error("data byte left write-back while the output was full");

    // Memory access steps never overlap.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.data_start, cmd.sch_rd_x, cmd.rd_y, cmd.wr_x, cmd.wr_y,
                  cmd.sch_clear}))
        else $error("two datapath steps issued in one cycle");

    // The schedule runs only after the final key byte was taken.
    a_sched_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCH_CLR) |-> $past(r_state == S_IDLE && i_in_valid
                                         && !i_op && i_last))
        else $error("key schedule started without a final key byte");

endmodule : rc4_ctrl

// ===== hdl/rc4_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 (ARCFOUR) byte stream cipher. Key bytes are stored, the final key byte
// runs the key schedule, and each data byte returns the byte XOR keystream.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_op, i_byte_in, i_last
// output    out        o_out_valid / i_out_stall o_out_byte
//
// After a data item is accepted, the core reads S[j], writes the first swap
// entry while reading the output entry, then writes the second; the result
// is registered and shows on the output at the end of that sequence. The
// sequence is set by the permutation memory, which takes one registered read
// and one write per cycle: three dependent reads and two writes per byte.
// A non-final key item is stored with no stall. The final key item stalls the
// input for the key schedule: a clear to identity, then 256 swap steps.
// Reset is synchronous and active low; it clears the per-entry valid bits
// at once, so the permutation reads as identity with no clearing pass.
// A stalled output does not block acceptance: a data item runs until its
// write-back and waits there only while the previous result is still unread.
//
module rc4_stream_cipher_core #(
    parameter int KEY_BYTES_MAX = rc4_pkg::KEY_BYTES_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [rc4_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rc4_pkg::BYTE_W-1:0]  o_out_byte
);
    import rc4_pkg::*;

    // Command and status groups between the controller and the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller decodes the item type, steps through the memory
    // accesses of one swap, and owns the valid of the output register.
    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // The datapath holds the permutation, the key store, the indices and
    // the output byte. Data bytes and the key schedule share the swap sequence;
    // the schedule adds a key byte into index j, data bytes load the output.
    rc4_dp #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_byte_in  (i_byte_in),
        .i_last     (i_last),
        .o_out_byte (o_out_byte)
    );

endmodule : rc4_stream_cipher_core
